// ===== hw/rtl/rfsg_pkg.sv =====
// Shared types, constants and helper functions for the rectangle fill frame generator.
// Used by every module under hw/rtl; depends on nothing else.

package rfsg_pkg;

    // Screen size in pixels.
    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 480;

    // Field and state widths.
    localparam int COORD_W   = 16;
    localparam int COLOUR_W  = 24;
    localparam int PIXCNT_W  = 24;
    localparam int HDR_W     = 4;
    localparam int BYTE_W    = 8;

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Display commands.
    localparam logic [BYTE_W-1:0] CMD_COLUMN_SET   = 8'h2A;
    localparam logic [BYTE_W-1:0] CMD_ROW_SET      = 8'h2B;
    localparam logic [BYTE_W-1:0] CMD_MEMORY_WRITE = 8'h2C;

    // Operation codes of an input item.
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // Header frame positions; HDR_PIXELS marks the pixel phase.
    localparam logic [HDR_W-1:0] HDR_COL_CMD      = 4'd0;
    localparam logic [HDR_W-1:0] HDR_COL_FIRST_HI = 4'd1;
    localparam logic [HDR_W-1:0] HDR_COL_FIRST_LO = 4'd2;
    localparam logic [HDR_W-1:0] HDR_COL_LAST_HI  = 4'd3;
    localparam logic [HDR_W-1:0] HDR_COL_LAST_LO  = 4'd4;
    localparam logic [HDR_W-1:0] HDR_ROW_CMD      = 4'd5;
    localparam logic [HDR_W-1:0] HDR_ROW_FIRST_HI = 4'd6;
    localparam logic [HDR_W-1:0] HDR_ROW_FIRST_LO = 4'd7;
    localparam logic [HDR_W-1:0] HDR_ROW_LAST_HI  = 4'd8;
    localparam logic [HDR_W-1:0] HDR_ROW_LAST_LO  = 4'd9;
    localparam logic [HDR_W-1:0] HDR_MEM_CMD      = 4'd10;
    localparam logic [HDR_W-1:0] HDR_PIXELS       = 4'd11;

    // Status reported for a start item.
    typedef enum logic [1:0] {
        STATUS_NONE,
        STATUS_ACCEPTED,
        STATUS_RANGE,
        STATUS_BUSY
    } status_t;

    // Colour component being sent within a pixel.
    typedef enum logic [1:0] {
        COMP_RED,
        COMP_GREEN,
        COMP_BLUE
    } comp_t;

    // One input item.
    typedef struct packed {
        logic               operation;
        logic [COORD_W-1:0] rect_x;
        logic [COORD_W-1:0] rect_y;
        logic [COORD_W-1:0] rect_width;
        logic [COORD_W-1:0] rect_height;
        logic [BYTE_W-1:0]  red;
        logic [BYTE_W-1:0]  green;
        logic [BYTE_W-1:0]  blue;
    } item_t;

    // One result item.
    typedef struct packed {
        logic              frame_valid;
        logic              data_flag;
        logic [BYTE_W-1:0] payload;
        logic              end_of_burst;
        logic              job_done;
        status_t           start_status;
    } result_t;

    // Classified item as it sits in the queue.
    typedef struct packed {
        logic                is_step;
        logic                in_range;
        logic [COORD_W-1:0]  col_first;
        logic [COORD_W-1:0]  col_last;
        logic [COORD_W-1:0]  row_first;
        logic [COORD_W-1:0]  row_last;
        logic [COORD_W-1:0]  width;
        logic [COORD_W-1:0]  height;
        logic [COLOUR_W-1:0] colour;
    } job_t;

    // A 9-bit display frame.
    typedef struct packed {
        logic              data_flag;
        logic [BYTE_W-1:0] payload;
    } frame_t;

    // Frame for one header position of the window setup sequence.
    function automatic frame_t header_frame(
        input logic [HDR_W-1:0]   idx,
        input logic [COORD_W-1:0] col_first,
        input logic [COORD_W-1:0] col_last,
        input logic [COORD_W-1:0] row_first,
        input logic [COORD_W-1:0] row_last
    );
        frame_t f;
        f.data_flag = 1'b1;
        f.payload   = CMD_MEMORY_WRITE;
        unique case (idx)
            HDR_COL_CMD:
            begin
                f.data_flag = 1'b0;
                f.payload   = CMD_COLUMN_SET;
            end
            HDR_COL_FIRST_HI: f.payload = col_first[15:8];
            HDR_COL_FIRST_LO: f.payload = col_first[7:0];
            HDR_COL_LAST_HI:  f.payload = col_last[15:8];
            HDR_COL_LAST_LO:  f.payload = col_last[7:0];
            HDR_ROW_CMD:
            begin
                f.data_flag = 1'b0;
                f.payload   = CMD_ROW_SET;
            end
            HDR_ROW_FIRST_HI: f.payload = row_first[15:8];
            HDR_ROW_FIRST_LO: f.payload = row_first[7:0];
            HDR_ROW_LAST_HI:  f.payload = row_last[15:8];
            HDR_ROW_LAST_LO:  f.payload = row_last[7:0];
            default:
            begin
                f.data_flag = 1'b0;
                f.payload   = CMD_MEMORY_WRITE;
            end
        endcase
        return f;
    endfunction

endpackage

// ===== hw/rtl/rect_fill_spi_frame_generator_top.sv =====
// Top level of the rectangle fill frame generator for a 9-bit SPI display link.
// Depends on rfsg_pkg, rfsg_front, rfsg_queue and rfsg_back.
//
//   Channel   Direction  Handshake                  Payload
//   item      in         item_valid / item_stall    rfsg_pkg::item_t
//   result    out        result_valid / result_stall rfsg_pkg::result_t
//
// One item is taken per cycle while item_stall is low and gives one result; the item
// is held in a queue entry before its result is written to the output register.
// The two-entry queue between front and back absorbs items while result_stall
// is high; item_stall rises when that queue is full.
// Reset leaves the generator idle with the queue and output register empty.

module rect_fill_spi_frame_generator_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  rfsg_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output rfsg_pkg::result_t result
);

    logic           queue_full;
    logic           push;
    rfsg_pkg::job_t push_job;
    logic           pop;
    logic           job_valid;
    rfsg_pkg::job_t job;

    rfsg_front u_front (
        .item       (item),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .queue_full (queue_full),
        .push       (push),
        .job        (push_job)
    );

    rfsg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (queue_full),
        .pop       (pop),
        .job_valid (job_valid),
        .job       (job)
    );

    rfsg_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (job_valid),
        .job          (job),
        .pop          (pop),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

endmodule

// ===== hw/rtl/rfsg_front.sv =====
// Front part: takes input items, checks start rectangles against the screen and clips them.
// Depends on rfsg_pkg; feeds rfsg_queue.

module rfsg_front (
    input  rfsg_pkg::item_t item,
    input  logic            item_valid,
    output logic            item_stall,
    input  logic            queue_full,
    output logic            push,
    output rfsg_pkg::job_t  job
);

    localparam logic [rfsg_pkg::COORD_W-1:0] SCR_W =
        rfsg_pkg::COORD_W'(rfsg_pkg::SCREEN_WIDTH);
    localparam logic [rfsg_pkg::COORD_W-1:0] SCR_H =
        rfsg_pkg::COORD_W'(rfsg_pkg::SCREEN_HEIGHT);

    logic [rfsg_pkg::COORD_W:0]   x_span;
    logic [rfsg_pkg::COORD_W:0]   y_span;
    logic [rfsg_pkg::COORD_W-1:0] width_clip;
    logic [rfsg_pkg::COORD_W-1:0] height_clip;

    // A transfer goes straight into the queue whenever it has room.
    assign item_stall = queue_full;
    assign push       = item_valid && !queue_full;

    // Clip the rectangle at the right and bottom screen edges.
    assign x_span = {1'b0, item.rect_x} + {1'b0, item.rect_width};
    assign y_span = {1'b0, item.rect_y} + {1'b0, item.rect_height};

    assign width_clip  = (x_span > {1'b0, SCR_W}) ? (SCR_W - item.rect_x) : item.rect_width;
    assign height_clip = (y_span > {1'b0, SCR_H}) ? (SCR_H - item.rect_y) : item.rect_height;

    // Build the queue entry.
    always_comb
    begin
        job.is_step   = (item.operation == rfsg_pkg::OP_STEP);
        job.in_range  = (item.rect_x < SCR_W) && (item.rect_y < SCR_H) &&
                        (item.rect_width != '0) && (item.rect_height != '0);
        job.col_first = item.rect_x;
        job.col_last  = item.rect_x + width_clip - rfsg_pkg::COORD_W'(1);
        job.row_first = item.rect_y;
        job.row_last  = item.rect_y + height_clip - rfsg_pkg::COORD_W'(1);
        job.width     = width_clip;
        job.height    = height_clip;
        job.colour    = {item.red, item.green, item.blue};
    end

endmodule

// ===== hw/rtl/rfsg_queue.sv =====
// Short register queue between the front and back parts.
// Depends on rfsg_pkg for the entry type and depth.

module rfsg_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  rfsg_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           job_valid,
    output rfsg_pkg::job_t job
);

    localparam logic [rfsg_pkg::QPTR_W-1:0] LAST_PTR =
        rfsg_pkg::QPTR_W'(rfsg_pkg::QUEUE_DEPTH - 1);
    localparam logic [rfsg_pkg::QCNT_W-1:0] DEPTH_CNT =
        rfsg_pkg::QCNT_W'(rfsg_pkg::QUEUE_DEPTH);

    rfsg_pkg::job_t                entry_reg [rfsg_pkg::QUEUE_DEPTH];
    logic [rfsg_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [rfsg_pkg::QPTR_W-1:0]   wr_ptr_next;
    logic [rfsg_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [rfsg_pkg::QPTR_W-1:0]   rd_ptr_next;
    logic [rfsg_pkg::QCNT_W-1:0]   count_reg;
    logic [rfsg_pkg::QCNT_W-1:0]   count_next;

    assign full      = (count_reg == DEPTH_CNT);
    assign job_valid = (count_reg != '0);
    assign job       = entry_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== hw/rtl/rfsg_back.sv =====
// Back part: holds the job state, carries out queued items and drives the result register.
// Depends on rfsg_pkg; takes entries from rfsg_queue.

module rfsg_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             job_valid,
    input  rfsg_pkg::job_t   job,
    output logic             pop,
    output rfsg_pkg::result_t result,
    output logic             result_valid,
    input  logic             result_stall
);

    logic                             busy_reg;
    logic                             busy_next;
    logic [rfsg_pkg::HDR_W-1:0]       header_index_reg;
    logic [rfsg_pkg::HDR_W-1:0]       header_index_next;
    logic [rfsg_pkg::COORD_W-1:0]     col_first_reg;
    logic [rfsg_pkg::COORD_W-1:0]     col_last_reg;
    logic [rfsg_pkg::COORD_W-1:0]     row_first_reg;
    logic [rfsg_pkg::COORD_W-1:0]     row_last_reg;
    logic [rfsg_pkg::COLOUR_W-1:0]    fill_colour_reg;
    logic [rfsg_pkg::PIXCNT_W-1:0]    pixels_left_reg;
    logic [rfsg_pkg::PIXCNT_W-1:0]    pixels_left_next;
    rfsg_pkg::comp_t                  component_reg;
    rfsg_pkg::comp_t                  component_next;
    logic                             load_job;
    logic [2*rfsg_pkg::COORD_W-1:0]   area;
    logic                             out_ready;
    logic                             result_valid_reg;
    logic                             result_valid_next;
    rfsg_pkg::result_t                result_reg;
    rfsg_pkg::result_t                result_next;
    rfsg_pkg::frame_t                 hdr;

    // The result register takes a new transfer when empty or being drained.
    assign out_ready         = !result_valid_reg || !result_stall;
    assign pop               = job_valid && out_ready;
    assign result_valid_next = out_ready ? job_valid : result_valid_reg;
    assign result_valid      = result_valid_reg;
    assign result            = result_reg;

    // Pixel count of the clipped rectangle.
    assign area = job.width * job.height;

    assign hdr = rfsg_pkg::header_frame(header_index_reg, col_first_reg, col_last_reg,
                                        row_first_reg, row_last_reg);

    // Execute the item at the head of the queue.
    always_comb
    begin
        busy_next         = busy_reg;
        header_index_next = header_index_reg;
        pixels_left_next  = pixels_left_reg;
        component_next    = component_reg;
        load_job          = 1'b0;
        result_next       = '0;

        if (!job.is_step)
        begin
            if (busy_reg)
            begin
                result_next.start_status = rfsg_pkg::STATUS_BUSY;
            end
            else if (!job.in_range)
            begin
                result_next.start_status = rfsg_pkg::STATUS_RANGE;
            end
            else
            begin
                result_next.start_status = rfsg_pkg::STATUS_ACCEPTED;
                load_job          = 1'b1;
                busy_next         = 1'b1;
                header_index_next = rfsg_pkg::HDR_COL_CMD;
                component_next    = rfsg_pkg::COMP_RED;
                pixels_left_next  = rfsg_pkg::PIXCNT_W'(area - 1'b1);
            end
        end
        else if (busy_reg)
        begin
            result_next.frame_valid = 1'b1;
            if (header_index_reg < rfsg_pkg::HDR_PIXELS)
            begin
                // Window setup and memory write command.
                result_next.data_flag    = hdr.data_flag;
                result_next.payload      = hdr.payload;
                result_next.end_of_burst = (header_index_reg == rfsg_pkg::HDR_COL_LAST_LO) ||
                                           (header_index_reg == rfsg_pkg::HDR_ROW_LAST_LO);
                header_index_next        = header_index_reg + 1'b1;
            end
            else
            begin
                // Pixel data, one colour component per frame.
                result_next.data_flag = 1'b1;
                case (component_reg)
                    rfsg_pkg::COMP_RED:
                    begin
                        result_next.payload = fill_colour_reg[23:16];
                        component_next      = rfsg_pkg::COMP_GREEN;
                    end
                    rfsg_pkg::COMP_GREEN:
                    begin
                        result_next.payload = fill_colour_reg[15:8];
                        component_next      = rfsg_pkg::COMP_BLUE;
                    end
                    default:
                    begin
                        result_next.payload = fill_colour_reg[7:0];
                        component_next      = rfsg_pkg::COMP_RED;
                        if (pixels_left_reg == '0)
                        begin
                            result_next.end_of_burst = 1'b1;
                            result_next.job_done     = 1'b1;
                            busy_next                = 1'b0;
                            header_index_next        = rfsg_pkg::HDR_COL_CMD;
                        end
                        else
                        begin
                            pixels_left_next = pixels_left_reg - 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b0;
            header_index_reg <= rfsg_pkg::HDR_COL_CMD;
            pixels_left_reg  <= '0;
            component_reg    <= rfsg_pkg::COMP_RED;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            if (pop)
            begin
                busy_reg         <= busy_next;
                header_index_reg <= header_index_next;
                pixels_left_reg  <= pixels_left_next;
                component_reg    <= component_next;
            end
        end
    end

    // Job window, colour and result payload.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            result_reg <= result_next;
        end
        if (pop && load_job)
        begin
            col_first_reg   <= job.col_first;
            col_last_reg    <= job.col_last;
            row_first_reg   <= job.row_first;
            row_last_reg    <= job.row_last;
            fill_colour_reg <= job.colour;
        end
    end

endmodule
